FILE: src/mvq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvq_pkg: shared types and constants for the macroblock vector unit
// Command codes, field widths, control bundles and the small lookup tables
// used by the quantiser tracker and the per-axis vector rebuild.
// ----------------------------------------------------------------------------
package mvq_pkg;

  localparam int unsigned QUANT_W   = 5;
  localparam int unsigned DIFF_W    = 13;
  localparam int unsigned PRED_W    = 12;
  localparam int unsigned MV_W      = 12;
  localparam int unsigned SUM_W     = 15;
  localparam int unsigned FCODE_W   = 3;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned DQ_W      = 2;
  localparam int unsigned BIDX_W    = 2;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic [QUANT_W-1:0] QUANT_MIN  = 5'd1;
  localparam logic [QUANT_W-1:0] QUANT_MAX  = 5'd31;
  localparam logic [FCODE_W-1:0] FCODE_RST  = 3'd1;
  localparam logic [BIDX_W-1:0]  BIDX_FIRST = 2'd0;
  localparam logic [BIDX_W-1:0]  BIDX_LAST  = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_FRAME_START = 3'd0,
    CMD_NOT_CODED   = 3'd1,
    CMD_INTRA       = 3'd2,
    CMD_INTRA_Q     = 3'd3,
    CMD_INTER       = 3'd4,
    CMD_INTER_Q     = 3'd5,
    CMD_INTER4V     = 3'd6
  } cmd_t;

  typedef struct packed {
    logic vec_en;
    logic four_v;
    logic first;
    logic chroma_en;
  } axis_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } quant_ctl_t;

  function automatic logic signed [6:0] dq_step(input logic [DQ_W-1:0] code);
    logic signed [6:0] s;
    case (code)
      2'd0:    s = -7'sd1;
      2'd1:    s = -7'sd2;
      2'd2:    s = 7'sd1;
      default: s = 7'sd2;
    endcase
    return s;
  endfunction

  function automatic logic [1:0] chroma_round(input logic [3:0] idx);
    logic [1:0] r;
    case (idx)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd14, 4'd15:     r = 2'd2;
      default:          r = 2'd1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/mvq_quant.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvq_quant: running quantiser
// Loads the frame quantiser on frame start and applies the clamped dquant
// step in the q-modes. Presents the quantiser in force after the current beat.
// ----------------------------------------------------------------------------
module mvq_quant (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         upd_en,
  input  wire mvq_pkg::quant_ctl_t    ctl,
  input  wire [mvq_pkg::QUANT_W-1:0]  start_quant,
  input  wire [mvq_pkg::DQ_W-1:0]     dquant_code,
  output logic [mvq_pkg::QUANT_W-1:0] quant_nxt
);
  import mvq_pkg::*;

  logic [QUANT_W-1:0] quant_r;
  logic signed [6:0]  q_sum;

  always_comb begin
    q_sum = signed'({2'b00, quant_r}) + dq_step(dquant_code);
    if (ctl.load) begin
      quant_nxt = (start_quant == '0) ? QUANT_MIN : start_quant;
    end else if (ctl.step) begin
      if (q_sum > signed'({2'b00, QUANT_MAX})) begin
        quant_nxt = QUANT_MAX;
      end else if (q_sum < signed'({2'b00, QUANT_MIN})) begin
        quant_nxt = QUANT_MIN;
      end else begin
        quant_nxt = q_sum[QUANT_W-1:0];
      end
    end else begin
      quant_nxt = quant_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quant_r <= QUANT_MIN;
    end else if (upd_en) begin
      quant_r <= quant_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/mvq_axis.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvq_axis: one axis of the vector rebuild
// Adds differential and predictor, wraps once into the fcode range, keeps the
// 4V running sum and derives the chroma component by the half or sum rule.
// ----------------------------------------------------------------------------
module mvq_axis (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         upd_en,
  input  wire mvq_pkg::axis_ctl_t     ctl,
  input  wire [mvq_pkg::FCODE_W-1:0]  fcode,
  input  wire [mvq_pkg::DIFF_W-1:0]   diff,
  input  wire [mvq_pkg::PRED_W-1:0]   pred,
  output logic [mvq_pkg::MV_W-1:0]    luma_mv,
  output logic [mvq_pkg::MV_W-1:0]    chroma_mv
);
  import mvq_pkg::*;

  logic [SUM_W-1:0]        sum_r;
  logic [SUM_W-1:0]        sum_nxt;
  logic [FCODE_W-1:0]      f_eff;
  logic signed [SUM_W-1:0] raw;
  logic signed [SUM_W-1:0] lim;
  logic signed [SUM_W-1:0] wrapped;
  logic [MV_W-1:0]         v;
  logic [MV_W-1:0]         half_mv;
  logic [SUM_W-1:0]        mag_abs;
  logic [MV_W:0]           mag;
  logic [MV_W:0]           neg_mag;
  logic [MV_W-1:0]         sum_mv;

  always_comb begin
    f_eff = (fcode == '0) ? FCODE_RST : fcode;
    lim   = signed'(SUM_W'(1) << ({1'b0, f_eff} + 4'd4));
    raw   = signed'({{(SUM_W-DIFF_W){diff[DIFF_W-1]}}, diff})
          + signed'({{(SUM_W-PRED_W){pred[PRED_W-1]}}, pred});
    if (raw < -lim) begin
      wrapped = raw + (lim <<< 1);
    end else if (raw > lim - 15'sd1) begin
      wrapped = raw - (lim <<< 1);
    end else begin
      wrapped = raw;
    end
    v       = wrapped[MV_W-1:0];
    half_mv = {v[MV_W-1], v[MV_W-1:1]} | {{(MV_W-1){1'b0}}, |v[1:0]};

    if (ctl.first) begin
      sum_nxt = {{(SUM_W-MV_W){v[MV_W-1]}}, v};
    end else begin
      sum_nxt = sum_r + {{(SUM_W-MV_W){v[MV_W-1]}}, v};
    end
    mag_abs = sum_nxt[SUM_W-1] ? (~sum_nxt + SUM_W'(1)) : sum_nxt;
    mag     = {1'b0, mag_abs[SUM_W-1:4], 1'b0}
            + {{(MV_W-1){1'b0}}, chroma_round(mag_abs[3:0])};
    neg_mag = ~mag + 13'd1;
    sum_mv  = sum_nxt[SUM_W-1] ? neg_mag[MV_W-1:0] : mag[MV_W-1:0];

    luma_mv = ctl.vec_en ? v : '0;
    if (!ctl.chroma_en) begin
      chroma_mv = '0;
    end else if (ctl.four_v) begin
      chroma_mv = sum_mv;
    end else begin
      chroma_mv = half_mv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (upd_en && ctl.four_v) begin
      sum_r <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/mpeg4_mb_vector_and_quant_update_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg4_mb_vector_and_quant_update_unit: macroblock quantiser and MV update
// Tracks the running quantiser and rebuilds luma and chroma motion vectors,
// one result beat for every macroblock command beat.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one macroblock command per beat; the command code
// travels in in_tuser and the remaining fields in in_tdata. The result stream
// returns exactly one beat per input beat, in order, with chroma_valid in
// out_tuser and the vectors and quantiser in out_tdata.
// The vector range code is written through cfg_wr_en/cfg_wr_data while the
// unit is idle.
// Each beat passes through one input register and one result register, with
// all arithmetic in between. Throughput is one beat per cycle while the
// receiver holds out_tready high.
// Reset clears both pipeline stages, sets the quantiser to 1, the 4V sums to
// zero and the range code to 1.
// When the receiver holds out_tready low the result beat stays stable; one
// further input beat is taken into the input register, after which in_tready
// falls until the result is taken.
// ----------------------------------------------------------------------------
module mpeg4_mb_vector_and_quant_update_unit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_tvalid,
  output logic                           in_tready,
  // start_quant[4:0], dquant_code[6:5], block_index[8:7], diff_x[21:9],
  // diff_y[34:22], pred_x[46:35], pred_y[58:47], zero fill [63:59]
  input  wire [mvq_pkg::IN_DATA_W-1:0]   in_tdata,
  // command[2:0]
  input  wire [mvq_pkg::CMD_W-1:0]       in_tuser,
  output logic                           out_tvalid,
  input  wire                            out_tready,
  // luma_mv_x[11:0], luma_mv_y[23:12], chroma_mv_x[35:24],
  // chroma_mv_y[47:36], current_quant[52:48], zero fill [55:53]
  output logic [mvq_pkg::OUT_DATA_W-1:0] out_tdata,
  // chroma_valid[0]
  output logic                           out_tuser,
  input  wire                            cfg_wr_en,
  input  wire [mvq_pkg::FCODE_W-1:0]     cfg_wr_data
);
  import mvq_pkg::*;

  logic                  s1_valid_r;
  logic [IN_DATA_W-1:0]  s1_data_r;
  logic [CMD_W-1:0]      s1_cmd_r;
  logic [FCODE_W-1:0]    fcode_r;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;
  logic                  out_free;
  logic                  adv;
  axis_ctl_t             axis_ctl;
  quant_ctl_t            quant_ctl;
  logic [QUANT_W-1:0]    quant_nxt;
  logic [MV_W-1:0]       luma_x, luma_y, chroma_x, chroma_y;
  logic                  is_last;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign is_last   = s1_data_r[8:7] == BIDX_LAST;

  always_comb begin
    axis_ctl  = '0;
    quant_ctl = '0;
    axis_ctl.first = s1_data_r[8:7] == BIDX_FIRST;
    unique case (s1_cmd_r)
      CMD_FRAME_START: quant_ctl.load = 1'b1;
      CMD_INTRA_Q:     quant_ctl.step = 1'b1;
      CMD_INTER: begin
        axis_ctl.vec_en    = 1'b1;
        axis_ctl.chroma_en = 1'b1;
      end
      CMD_INTER_Q: begin
        quant_ctl.step     = 1'b1;
        axis_ctl.vec_en    = 1'b1;
        axis_ctl.chroma_en = 1'b1;
      end
      CMD_INTER4V: begin
        axis_ctl.vec_en    = 1'b1;
        axis_ctl.four_v    = 1'b1;
        axis_ctl.chroma_en = is_last;
      end
      default: begin
      end
    endcase
  end

  mvq_quant u_quant (
    .clk         (clk),
    .rst_n       (rst_n),
    .upd_en      (adv),
    .ctl         (quant_ctl),
    .start_quant (s1_data_r[4:0]),
    .dquant_code (s1_data_r[6:5]),
    .quant_nxt   (quant_nxt)
  );

  mvq_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (adv),
    .ctl       (axis_ctl),
    .fcode     (fcode_r),
    .diff      (s1_data_r[21:9]),
    .pred      (s1_data_r[46:35]),
    .luma_mv   (luma_x),
    .chroma_mv (chroma_x)
  );

  mvq_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd_en    (adv),
    .ctl       (axis_ctl),
    .fcode     (fcode_r),
    .diff      (s1_data_r[34:22]),
    .pred      (s1_data_r[58:47]),
    .luma_mv   (luma_y),
    .chroma_mv (chroma_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcode_r <= FCODE_RST;
    end else if (cfg_wr_en) begin
      fcode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_data_r <= in_tdata;
      s1_cmd_r  <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {3'b000, quant_nxt, chroma_y, chroma_x, luma_y, luma_x};
      out_user_r <= axis_ctl.chroma_en;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

FILE: src/mvq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvq_checker: port-level checks for the macroblock vector unit
// Watches the result stream for reset behaviour, stall stability and the
// invariants of the quantiser and chroma fields.
// ----------------------------------------------------------------------------
module mvq_checker (
  input wire                            clk,
  input wire                            rst_n,
  input wire                            out_tvalid,
  input wire                            out_tready,
  input wire [mvq_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                            out_tuser
);
  import mvq_pkg::*;

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat valid straight after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed");

  a_quant_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[52:48] != 5'd0)
    else $error("quantiser of zero on a result beat");

  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[47:24] == 24'd0)
    else $error("chroma vector not zero while chroma is not valid");

endmodule

bind mpeg4_mb_vector_and_quant_update_unit mvq_checker u_mvq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
